>>> rtl/bfs_pkg.sv
`timescale 1ns / 1ps

package bfs_pkg;

    // Fixed field widths.
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int COEF_W     = 16;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVE_COEFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DISTANCE = 2'd2;

    // Register reset values.
    localparam logic [CNT_W-1:0]  RST_FILTER_COUNT   = 5'd0;
    localparam logic [COEF_W-1:0] RST_RESERVE_COEFF  = 16'd2621;
    localparam logic [DIST_W-1:0] RST_START_DISTANCE = 32'd10000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;     // store the accepted entry
        logic start;     // latch the query and preset the running best
        logic rd_en;     // read one table slot into the pipeline
        logic load_out;  // move the selection into the output word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;      // a slot read is still in the compare pipeline
    } t_status;

endpackage

>>> rtl/bfs_if.sv
`timescale 1ns / 1ps

interface bfs_in_if #(
    parameter int FREQ_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [bfs_pkg::IDX_W-1:0]    entry_index;
    logic [FREQ_WIDTH-1:0]        entry_low_freq;
    logic [FREQ_WIDTH-1:0]        entry_high_freq;
    logic [FREQ_WIDTH-1:0]        query_freq;

    modport source (
        output valid, req_type, entry_index, entry_low_freq, entry_high_freq, query_freq,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_low_freq, entry_high_freq, query_freq,
        output ready
    );
endinterface

interface bfs_out_if #(
    parameter int FREQ_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [bfs_pkg::IDX_W-1:0]    best_index;
    logic [FREQ_WIDTH-1:0]        best_low_freq;
    logic [FREQ_WIDTH-1:0]        best_high_freq;

    modport source (
        output valid, found, best_index, best_low_freq, best_high_freq,
        input  ready
    );
    modport sink (
        input  valid, found, best_index, best_low_freq, best_high_freq,
        output ready
    );
endinterface

interface bfs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bfs_pkg::CFG_IDX_W-1:0]     index;
    logic [bfs_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/band_filter_select_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Word
// i_in      in   write request (slot and band) or query frequency
// o_out     out  found flag, winning slot and its band
// i_cfg     in   register index and data: count, reserve, start distance
//
// A write request is stored in the table as it is accepted. A query with at least
// one slot in use reads and compares one slot per cycle through a three-stage
// read/compare pipeline, then drains it and loads the result; with none in use it
// goes straight to drain and result. Synchronous active-low reset clears control
// and configuration; the band table is not cleared. A result that is not taken holds
// the block at the end of the next query only; writes still go in.
module band_filter_select_core #(
    parameter int MAX_FILTERS = 16,
    parameter int FREQ_WIDTH  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfs_in_if.sink     i_in,
    bfs_out_if.source  o_out,
    bfs_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int CW = $clog2(MAX_FILTERS + 1);

    logic [bfs_pkg::CNT_W-1:0]  r_filter_count;
    logic [bfs_pkg::COEF_W-1:0] r_reserve_coeff;
    logic [bfs_pkg::DIST_W-1:0] r_start_distance;
    logic [CW-1:0]              count_sat;

    bfs_pkg::t_cmd    cmd;
    bfs_pkg::t_status status;
    logic [AW-1:0]    rd_addr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_count   <= bfs_pkg::RST_FILTER_COUNT;
            r_reserve_coeff  <= bfs_pkg::RST_RESERVE_COEFF;
            r_start_distance <= bfs_pkg::RST_START_DISTANCE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bfs_pkg::REG_FILTER_COUNT:
                    r_filter_count <= i_cfg.data[bfs_pkg::CNT_W-1:0];
                bfs_pkg::REG_RESERVE_COEFF:
                    r_reserve_coeff <= i_cfg.data[bfs_pkg::COEF_W-1:0];
                bfs_pkg::REG_START_DISTANCE:
                    r_start_distance <= i_cfg.data[bfs_pkg::DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign count_sat = (32'(r_filter_count) > MAX_FILTERS) ? CW'(MAX_FILTERS)
                                                           : CW'(r_filter_count);

    bfs_ctrl #(
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_type  (i_in.req_type),
        .i_count     (count_sat),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    bfs_dpath #(
        .MAX_FILTERS (MAX_FILTERS),
        .FREQ_WIDTH  (FREQ_WIDTH),
        .AW          (AW)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .i_wr_index       (i_in.entry_index),
        .i_wr_low         (i_in.entry_low_freq),
        .i_wr_high        (i_in.entry_high_freq),
        .i_query          (i_in.query_freq),
        .i_reserve_coeff  (r_reserve_coeff),
        .i_start_distance (r_start_distance),
        .o_status         (status),
        .o_found          (o_out.found),
        .o_best_index     (o_out.best_index),
        .o_best_low       (o_out.best_low_freq),
        .o_best_high      (o_out.best_high_freq)
    );

endmodule

>>> rtl/bfs_ctrl.sv
`timescale 1ns / 1ps

module bfs_ctrl #(
    parameter int AW          = 4,
    parameter int CW          = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    input  logic [CW-1:0]      i_count,
    input  logic               i_out_ready,
    input  bfs_pkg::t_status   i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output bfs_pkg::t_cmd      o_cmd,
    output logic [AW-1:0]      o_rd_addr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic          accept;
    logic          out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.write    = accept && (i_req_type == bfs_pkg::REQ_WRITE);
        o_cmd.start    = accept && (i_req_type == bfs_pkg::REQ_QUERY);
        o_cmd.rd_en    = (r_state == S_WALK);
        o_cmd.load_out = (r_state == S_DONE) && out_free;
    end

    assign o_rd_addr   = r_cnt[AW-1:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == bfs_pkg::REQ_QUERY)) begin
                        r_cnt   <= '0;
                        r_state <= (i_count == '0) ? S_DRAIN : S_WALK;
                    end
                end
                S_WALK: begin
                    if ((r_cnt + 1'b1) == i_count) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_status.busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/bfs_dpath.sv
`timescale 1ns / 1ps

module bfs_dpath #(
    parameter int MAX_FILTERS = 16,
    parameter int FREQ_WIDTH  = 32,
    parameter int AW          = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfs_pkg::t_cmd                 i_cmd,
    input  logic [AW-1:0]                 i_rd_addr,
    input  logic [bfs_pkg::IDX_W-1:0]     i_wr_index,
    input  logic [FREQ_WIDTH-1:0]         i_wr_low,
    input  logic [FREQ_WIDTH-1:0]         i_wr_high,
    input  logic [FREQ_WIDTH-1:0]         i_query,
    input  logic [bfs_pkg::COEF_W-1:0]    i_reserve_coeff,
    input  logic [bfs_pkg::DIST_W-1:0]    i_start_distance,
    output bfs_pkg::t_status              o_status,
    output logic                          o_found,
    output logic [bfs_pkg::IDX_W-1:0]     o_best_index,
    output logic [FREQ_WIDTH-1:0]         o_best_low,
    output logic [FREQ_WIDTH-1:0]         o_best_high
);

    localparam int W  = FREQ_WIDTH;
    localparam int CF = bfs_pkg::COEF_W;
    localparam int BW = (W > bfs_pkg::DIST_W) ? W : bfs_pkg::DIST_W;
    localparam int PW = W + CF;

    logic [W-1:0] mem_low  [MAX_FILTERS];
    logic [W-1:0] mem_high [MAX_FILTERS];

    logic          wr_ok;
    logic [AW-1:0] wr_addr;

    // Stage 1: registered table read.
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_idx;
    logic [W-1:0]  r_s1_low;
    logic [W-1:0]  r_s1_high;

    // Stage 2: midpoint test, distance and reserve product.
    logic          r_s2_valid;
    logic [AW-1:0] r_s2_idx;
    logic [W-1:0]  r_s2_low;
    logic [W-1:0]  r_s2_high;
    logic          r_s2_mid_ok;
    logic          r_s2_q_lt_hi;
    logic [W-1:0]  r_s2_dist;
    logic [PW-1:0] r_s2_prod;

    // Running selection.
    logic [W-1:0]  r_query;
    logic [BW-1:0] r_best;
    logic          r_found;
    logic [AW-1:0] r_win_idx;
    logic [W-1:0]  r_win_low;
    logic [W-1:0]  r_win_high;

    logic [W+1:0]  n_mid2;
    logic [W+1:0]  n_q2;
    logic [W-1:0]  n_dist;
    logic          n_up_ok;
    logic          n_take;

    assign wr_ok   = (32'(i_wr_index) < MAX_FILTERS);
    assign wr_addr = AW'(i_wr_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            mem_low[wr_addr]  <= i_wr_low;
            mem_high[wr_addr] <= i_wr_high;
        end
        if (i_cmd.rd_en) begin
            r_s1_low  <= mem_low[i_rd_addr];
            r_s1_high <= mem_high[i_rd_addr];
            r_s1_idx  <= i_rd_addr;
        end
    end

    // Twice the midpoint is lo + hi for an ordered band and 3*lo - hi otherwise.
    always_comb begin
        if (r_s1_high >= r_s1_low) begin
            n_mid2 = {2'b00, r_s1_low} + {2'b00, r_s1_high};
        end else begin
            n_mid2 = ({1'b0, r_s1_low, 1'b0} + {2'b00, r_s1_low}) - {2'b00, r_s1_high};
        end
        n_q2   = {1'b0, r_query, 1'b0};
        n_dist = (r_query >= r_s1_high) ? (r_query - r_s1_high) : (r_s1_high - r_query);
    end

    always_ff @(posedge i_clk) begin
        r_s2_idx     <= r_s1_idx;
        r_s2_low     <= r_s1_low;
        r_s2_high    <= r_s1_high;
        r_s2_mid_ok  <= (n_q2 > n_mid2);
        r_s2_q_lt_hi <= (r_query < r_s1_high);
        r_s2_dist    <= n_dist;
        r_s2_prod    <= PW'(r_s1_high) * PW'(i_reserve_coeff);
    end

    // q < hi + ceil(hi*c/65536) holds when q < hi, or when q - hi is below the
    // rounded-up reserve, which is the same as hi*c > (q - hi) * 65536.
    assign n_up_ok = r_s2_q_lt_hi || (r_s2_prod > {r_s2_dist, {CF{1'b0}}});
    assign n_take  = r_s2_valid && r_s2_mid_ok && n_up_ok && (BW'(r_s2_dist) < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s2_valid <= r_s1_valid;
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (n_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_query <= i_query;
            r_best  <= BW'(i_start_distance);
        end else if (n_take) begin
            r_best     <= BW'(r_s2_dist);
            r_win_idx  <= r_s2_idx;
            r_win_low  <= r_s2_low;
            r_win_high <= r_s2_high;
        end
        if (i_cmd.load_out) begin
            o_found      <= r_found;
            o_best_index <= r_found ? bfs_pkg::IDX_W'(r_win_idx) : '0;
            o_best_low   <= r_found ? r_win_low : '0;
            o_best_high  <= r_found ? r_win_high : '0;
        end
    end

    assign o_status.busy = r_s1_valid || r_s2_valid;

endmodule

>>> rtl/bfs_checker.sv
`timescale 1ns / 1ps

module bfs_checker #(
    parameter int FREQ_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_req_type,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_found,
    input logic [bfs_pkg::IDX_W-1:0]    i_best_index,
    input logic [FREQ_WIDTH-1:0]        i_best_low,
    input logic [FREQ_WIDTH-1:0]        i_best_high
);

    // A stalled result word keeps its valid and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_found) && $stable(i_best_index)
            && $stable(i_best_low) && $stable(i_best_high))
        else $error("result word changed while stalled");

    // A query keeps the input side closed while the table is walked.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_req_type == bfs_pkg::REQ_QUERY) |=> !i_in_ready)
        else $error("input accepted during a query");

    // A table write never produces a result word.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_req_type == bfs_pkg::REQ_WRITE) && !i_out_valid
            |=> !i_out_valid)
        else $error("result appeared after a table write");

    // A miss reports a zero slot and zero bounds.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |->
            (i_best_index == '0) && (i_best_low == '0) && (i_best_high == '0))
        else $error("miss result carries nonzero fields");

endmodule

bind band_filter_select_core bfs_checker #(
    .FREQ_WIDTH (FREQ_WIDTH)
) u_bfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_req_type   (i_in.req_type),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.found),
    .i_best_index (o_out.best_index),
    .i_best_low   (o_out.best_low_freq),
    .i_best_high  (o_out.best_high_freq)
);
